// ===== rtl/armt_pkg.sv =====
package armt_pkg;

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned TAG_W  = 8;
   localparam int unsigned SLOT_W = 4;

   // request codes; code 3 is unused and answers a miss
   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_MISS      = 3'd1,
      STAT_OVERLAP   = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_BAD_RANGE = 3'd4,
      STAT_CLEARED   = 3'd5
   } status_type;

   // table update issued by the resolve logic
   typedef struct packed {
      logic write;
      logic clear;
   } table_cmd_type;

   typedef struct packed {
      status_type          status;
      logic                hit;
      logic [TAG_W-1:0]    tag;
      logic [SLOT_W-1:0]   slot;
   } rsp_type;

endpackage

// ===== rtl/address_range_match_table_core.sv =====
// Channel   | Ports                                            | Dir | Handshake
// ----------+--------------------------------------------------+-----+----------------------------
// request   | start, busy, req_type, req_address,              | in  | taken when start && !busy
//           | req_low_bound, req_high_bound, req_tag_in        |     |
// response  | rsp_strobe, rsp_status, rsp_hit, rsp_tag_out,    | out | one cycle, marked by strobe
//           | rsp_slot                                         |     |
//
// One request per cycle, sustained. A request taken into the input register is resolved
// against all slots at once; its response is then registered and shown on the rsp_ ports
// for a single cycle. The table is updated at the same edge the response is registered,
// so the next request always sees it. The input and response registers sit around the
// parallel slot compare. Reset clears the slot valid bits at once; busy is held high by
// reset and clears on the first clock edge without reset, low from then on.
// The receiver cannot stall: every response is shown exactly once.
module address_range_match_table_core
   import armt_pkg::*;
#(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [ADDR_W-1:0]   req_low_bound,
   input  logic [ADDR_W-1:0]   req_high_bound,
   input  logic [TAG_W-1:0]    req_tag_in,
   // response channel
   output logic                rsp_strobe,
   output logic [2:0]          rsp_status,
   output logic                rsp_hit,
   output logic [TAG_W-1:0]    rsp_tag_out,
   output logic [SLOT_W-1:0]   rsp_slot
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);

   // ---- control ----
   logic busy_ff, busy_in;
   logic req_valid_ff, req_valid_in;
   logic rsp_strobe_ff, rsp_strobe_in;

   // ---- request register (payload, no reset) ----
   logic [1:0]        req_type_ff;
   logic [ADDR_W-1:0] req_address_ff;
   logic [ADDR_W-1:0] req_low_ff;
   logic [ADDR_W-1:0] req_high_ff;
   logic [TAG_W-1:0]  req_tag_ff;

   // ---- response register ----
   rsp_type rsp_ff, rsp_in;

   // ---- between slot array and resolve ----
   logic [ENTRIES-1:0] valid_vec;
   logic [ENTRIES-1:0] match_vec;
   logic [ENTRIES-1:0] overlap_vec;
   logic [IDX_W-1:0]   rd_idx;
   logic [IDX_W-1:0]   wr_idx;
   logic [TAG_W-1:0]   rd_tag;
   table_cmd_type      cmd;
   table_cmd_type      cmd_gated;
   rsp_type            rsp_calc;

   logic req_fire;

   assign req_fire      = start && !busy_ff;
   assign busy_in       = 1'b0;
   assign req_valid_in  = req_fire;
   assign rsp_strobe_in = req_valid_ff;
   assign rsp_in        = rsp_calc;

   // table changes only for a request actually held in the input register
   assign cmd_gated.write = cmd.write && req_valid_ff;
   assign cmd_gated.clear = cmd.clear && req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         req_valid_ff  <= req_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_type_ff    <= req_type;
         req_address_ff <= req_address;
         req_low_ff     <= req_low_bound;
         req_high_ff    <= req_high_bound;
         req_tag_ff     <= req_tag_in;
      end
      rsp_ff <= rsp_in;
   end

   armt_slot_array #(
      .ENTRIES (ENTRIES)
   ) u_slots (
      .clock       (clock),
      .reset       (reset),
      .key_addr    (req_address_ff),
      .key_low     (req_low_ff),
      .key_high    (req_high_ff),
      .valid_vec   (valid_vec),
      .match_vec   (match_vec),
      .overlap_vec (overlap_vec),
      .rd_idx      (rd_idx),
      .rd_tag      (rd_tag),
      .cmd         (cmd_gated),
      .wr_idx      (wr_idx),
      .wr_tag      (req_tag_ff)
   );

   armt_resolve #(
      .ENTRIES (ENTRIES)
   ) u_resolve (
      .req_code    (req_type_ff),
      .low_bound   (req_low_ff),
      .high_bound  (req_high_ff),
      .tag_in      (req_tag_ff),
      .valid_vec   (valid_vec),
      .match_vec   (match_vec),
      .overlap_vec (overlap_vec),
      .rd_tag      (rd_tag),
      .rd_idx      (rd_idx),
      .wr_idx      (wr_idx),
      .cmd         (cmd),
      .rsp         (rsp_calc)
   );

   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_status  = rsp_ff.status;
   assign rsp_hit     = rsp_ff.hit;
   assign rsp_tag_out = rsp_ff.tag;
   assign rsp_slot    = rsp_ff.slot;

   // every accepted request gets its response strobe after the input and response registers
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##2 rsp_strobe)
      else $error("response missing two cycles after request");

   // a hit always reports success
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_hit |-> rsp_status == STAT_OK)
      else $error("hit with non-ok status");

   // failed or non-hit responses carry no tag or slot
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_hit |-> rsp_tag_out == '0 && rsp_slot == '0)
      else $error("non-hit response with nonzero tag or slot");

   // a successful insert leaves its slot valid
   a_insert_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_gated.write |=> valid_vec[$past(wr_idx)])
      else $error("inserted slot not valid");

   // a clear empties the table
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_gated.clear |=> valid_vec == '0)
      else $error("table not empty after clear");

endmodule

// ===== rtl/armt_slot_array.sv =====
module armt_slot_array
   import armt_pkg::*;
#(
   parameter int unsigned ENTRIES = 16,
   localparam int unsigned IDX_W = $clog2(ENTRIES)
) (
   input  logic                clock,
   input  logic                reset,
   // compare keys, from the request register
   input  logic [ADDR_W-1:0]   key_addr,
   input  logic [ADDR_W-1:0]   key_low,
   input  logic [ADDR_W-1:0]   key_high,
   // per-slot compare results
   output logic [ENTRIES-1:0]  valid_vec,
   output logic [ENTRIES-1:0]  match_vec,
   output logic [ENTRIES-1:0]  overlap_vec,
   // tag read for the matching slot
   input  logic [IDX_W-1:0]    rd_idx,
   output logic [TAG_W-1:0]    rd_tag,
   // update
   input  table_cmd_type       cmd,
   input  logic [IDX_W-1:0]    wr_idx,
   input  logic [TAG_W-1:0]    wr_tag
);

   logic [ENTRIES-1:0] valid_ff;
   logic [ADDR_W-1:0]  start_ff [ENTRIES];
   logic [ADDR_W-1:0]  stop_ff  [ENTRIES];
   logic [TAG_W-1:0]   tag_ff   [ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.clear) begin
         valid_ff <= '0;
      end else if (cmd.write) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // payload, no reset: only read behind a valid bit
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         start_ff[wr_idx] <= key_low;
         stop_ff[wr_idx]  <= key_high;
         tag_ff[wr_idx]   <= wr_tag;
      end
   end

   // one comparator set per slot, all in parallel
   always_comb begin
      for (int i = 0; i < int'(ENTRIES); i++) begin
         match_vec[i]   = valid_ff[i] && (key_addr >= start_ff[i]) && (key_addr <= stop_ff[i]);
         overlap_vec[i] = valid_ff[i] && (key_high >= start_ff[i]) && (key_low <= stop_ff[i]);
      end
   end

   assign valid_vec = valid_ff;
   assign rd_tag    = tag_ff[rd_idx];

endmodule

// ===== rtl/armt_resolve.sv =====
module armt_resolve
   import armt_pkg::*;
#(
   parameter int unsigned ENTRIES = 16,
   localparam int unsigned IDX_W = $clog2(ENTRIES)
) (
   input  logic [1:0]          req_code,
   input  logic [ADDR_W-1:0]   low_bound,
   input  logic [ADDR_W-1:0]   high_bound,
   input  logic [TAG_W-1:0]    tag_in,
   input  logic [ENTRIES-1:0]  valid_vec,
   input  logic [ENTRIES-1:0]  match_vec,
   input  logic [ENTRIES-1:0]  overlap_vec,
   input  logic [TAG_W-1:0]    rd_tag,
   output logic [IDX_W-1:0]    rd_idx,
   output logic [IDX_W-1:0]    wr_idx,
   output table_cmd_type       cmd,
   output rsp_type             rsp
);

   logic [ENTRIES-1:0] free_vec;
   logic               any_match;
   logic               any_overlap;
   logic               any_free;

   assign free_vec    = ~valid_vec;
   assign any_match   = |match_vec;
   assign any_overlap = |overlap_vec;
   assign any_free    = |free_vec;

   // lowest set bit wins
   always_comb begin
      rd_idx = '0;
      wr_idx = '0;
      for (int i = int'(ENTRIES) - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            rd_idx = IDX_W'(i);
         end
         if (free_vec[i]) begin
            wr_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      cmd        = '0;
      rsp.status = STAT_MISS;
      rsp.hit    = 1'b0;
      rsp.tag    = '0;
      rsp.slot   = '0;
      unique case (req_code_type'(req_code))
         REQ_LOOKUP: begin
            if (any_match) begin
               rsp.status = STAT_OK;
               rsp.hit    = 1'b1;
               rsp.tag    = rd_tag;
               rsp.slot   = SLOT_W'(rd_idx);
            end
         end
         REQ_INSERT: begin
            priority if (!(low_bound < high_bound)) begin
               rsp.status = STAT_BAD_RANGE;
            end else if (any_overlap) begin
               rsp.status = STAT_OVERLAP;
            end else if (!any_free) begin
               rsp.status = STAT_FULL;
            end else begin
               cmd.write  = 1'b1;
               rsp.status = STAT_OK;
               rsp.hit    = 1'b1;
               rsp.tag    = tag_in;
               rsp.slot   = SLOT_W'(wr_idx);
            end
         end
         REQ_CLEAR: begin
            cmd.clear  = 1'b1;
            rsp.status = STAT_CLEARED;
         end
         default: begin
            rsp.status = STAT_MISS;
         end
      endcase
   end

endmodule
